### rtl/clni_pkg.sv
// Shared constants, step codes and types for the character LCD nibble interface.
`timescale 1ns / 1ps
`default_nettype none

package clni_pkg;

  // Timebase: tick items per microsecond.
  localparam int TICKS_PER_US = 1;

  localparam int WAIT_MAX = 50000 * TICKS_PER_US;
  localparam int WAIT_W   = $clog2(WAIT_MAX + 1);
  localparam int PHASE_W  = 6;

  localparam logic [WAIT_W-1:0] DUR_POWER_ON = WAIT_W'(50000 * TICKS_PER_US);
  localparam logic [WAIT_W-1:0] DUR_WAKE_1   = WAIT_W'(5000 * TICKS_PER_US);
  localparam logic [WAIT_W-1:0] DUR_WAKE_N   = WAIT_W'(200 * TICKS_PER_US);
  localparam logic [WAIT_W-1:0] DUR_BYTE     = WAIT_W'(2000 * TICKS_PER_US);
  localparam logic [WAIT_W-1:0] DUR_GAP      = WAIT_W'(100 * TICKS_PER_US);
  localparam logic [WAIT_W-1:0] DUR_PULSE    = WAIT_W'(1 * TICKS_PER_US);

  // Sequence steps.
  localparam logic [PHASE_W-1:0] PH_POWER   = PHASE_W'(0);
  localparam logic [PHASE_W-1:0] PH_WAKE    = PHASE_W'(1);
  localparam logic [PHASE_W-1:0] PH_FS      = PHASE_W'(12);
  localparam logic [PHASE_W-1:0] PH_CLR_X   = PHASE_W'(27);
  localparam logic [PHASE_W-1:0] PH_EM      = PHASE_W'(28);
  localparam logic [PHASE_W-1:0] PH_IDLE    = PHASE_W'(33);
  localparam logic [PHASE_W-1:0] PH_USER    = PHASE_W'(34);
  localparam logic [PHASE_W-1:0] PH_LAST    = PHASE_W'(38);

  // Input command codes.
  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_INSTR = 2'd1;
  localparam logic [1:0] CMD_CHAR  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_FUNCTION_SET    = 2'd0;
  localparam logic [1:0] CFG_DISPLAY_CONTROL = 2'd1;
  localparam logic [1:0] CFG_ENTRY_MODE      = 2'd2;

  localparam logic [7:0] RST_FUNCTION_SET    = 8'h28;
  localparam logic [7:0] RST_DISPLAY_CONTROL = 8'h0C;
  localparam logic [7:0] RST_ENTRY_MODE      = 8'h06;
  localparam logic [7:0] CLEAR_CMD           = 8'h01;

  localparam logic [3:0] NIB_WAKE     = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT = 4'h2;

  typedef enum logic [1:0] {
    NIB_KEEP,
    NIB_CONST,
    NIB_HIGH,
    NIB_LOW
  } nib_src_t;

  typedef enum logic [2:0] {
    LD_NONE,
    LD_FUNC,
    LD_DISP,
    LD_CLEAR,
    LD_ENTRY
  } load_src_t;

  // What one sequence step does; a driven nibble also raises the strobe.
  typedef struct packed {
    load_src_t         load;
    nib_src_t          nib;
    logic [3:0]        nib_const;
    logic              strobe_clr;
    logic [WAIT_W-1:0] dur;
  } step_t;

endpackage

`default_nettype wire

### rtl/clni_step_decode.sv
// Step decoder: maps a sequence phase to its pin action and duration.
`timescale 1ns / 1ps
`default_nettype none

module clni_step_decode import clni_pkg::*; (
  input  logic [PHASE_W-1:0] phase,
  output step_t              step
);

  function automatic step_t byte_step(input logic [2:0] k);
    step_t s;
    s = '{load: LD_NONE, nib: NIB_KEEP, nib_const: 4'h0, strobe_clr: 1'b0, dur: DUR_BYTE};
    case (k)
      3'd0: begin
        s.nib = NIB_HIGH;
        s.dur = DUR_PULSE;
      end
      3'd2: begin
        s.nib = NIB_LOW;
        s.dur = DUR_PULSE;
      end
      3'd1, 3'd3: begin
        s.strobe_clr = 1'b1;
        s.dur        = DUR_GAP;
      end
      default: s.dur = DUR_BYTE;
    endcase
    return s;
  endfunction

  always_comb begin
    logic [PHASE_W-1:0] off;
    logic [1:0]         grp;
    logic [PHASE_W-1:0] k;
    step = '{load: LD_NONE, nib: NIB_KEEP, nib_const: 4'h0, strobe_clr: 1'b0, dur: DUR_BYTE};
    off  = '0;
    grp  = '0;
    k    = '0;
    if (phase == PH_POWER) begin
      step.dur = DUR_POWER_ON;
    end else if (phase < PH_FS) begin
      // Wake-up nibbles: pulse, gap, settle per group; the 4-bit one has no settle.
      off = phase - PH_WAKE;
      grp = (off >= 6'd9) ? 2'd3 : (off >= 6'd6) ? 2'd2 : (off >= 6'd3) ? 2'd1 : 2'd0;
      k   = off - PHASE_W'(3 * grp);
      case (k[1:0])
        2'd0: begin
          step.nib       = NIB_CONST;
          step.nib_const = (grp == 2'd3) ? NIB_FOUR_BIT : NIB_WAKE;
          step.dur       = DUR_PULSE;
        end
        2'd1: begin
          step.strobe_clr = 1'b1;
          step.dur        = DUR_GAP;
        end
        default: step.dur = (grp == 2'd0) ? DUR_WAKE_1 : DUR_WAKE_N;
      endcase
    end else if (phase < PH_CLR_X) begin
      off  = phase - PH_FS;
      grp  = (off >= 6'd10) ? 2'd2 : (off >= 6'd5) ? 2'd1 : 2'd0;
      k    = off - PHASE_W'(5 * grp);
      step = byte_step(k[2:0]);
      if (k == '0) begin
        case (grp)
          2'd0:    step.load = LD_FUNC;
          2'd1:    step.load = LD_DISP;
          default: step.load = LD_CLEAR;
        endcase
      end
    end else if (phase == PH_CLR_X) begin
      step.dur = DUR_BYTE;
    end else if (phase < PH_IDLE) begin
      k    = phase - PH_EM;
      step = byte_step(k[2:0]);
      if (phase == PH_EM) step.load = LD_ENTRY;
    end else if (phase >= PH_USER && phase <= PH_LAST) begin
      k    = phase - PH_USER;
      step = byte_step(k[2:0]);
    end
  end

endmodule

`default_nettype wire

### rtl/char_lcd_nibble_interface_unit.sv
// Top level of the character LCD nibble interface: sequencer state and stream ports.
//
// Drives a standard character LCD controller over a 4-bit bus. Every request on the
// slave stream is either a timebase tick (tuser = tick), or a byte to send as an
// instruction or as a character; each request yields exactly one result on the
// master stream carrying the current pin levels plus busy and refused flags.
// After reset the block runs the power-on sequence (50 ms wait, three wake-up
// nibbles, the 4-bit nibble, then function set, display control, clear with an
// extra 2 ms, entry mode) as ticks arrive; a send request while busy is dropped
// and flagged as refused. Ticks count in units of 1/TICKS_PER_US microseconds.
// One request per clock cycle while the consumer keeps up, with the result in the
// next cycle: the step decoder and the wait-counter decrement sit between the
// sequencer state registers and the result register, and a result that waits
// for the consumer is held in that register while the next request is taken as
// soon as it drains. Configuration registers are read by the init sequence at
// the moment each byte starts, so write them before the matching step or while idle.
`timescale 1ns / 1ps
`default_nettype none

module char_lcd_nibble_interface_unit import clni_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // Request stream
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
  input  logic [1:0] s_axis_tuser,   // [1:0] cmd
  // Result stream
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [3:0] data_nibble, [4] reg_select,
                                     // [5] enable_pin, [6] busy_res, [7] refused
  // Configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  // Configuration registers
  logic [7:0] function_set;
  logic [7:0] display_control;
  logic [7:0] entry_mode;

  // Sequencer state
  logic [PHASE_W-1:0] phase;
  logic [WAIT_W-1:0]  wait_ticks;
  logic [7:0]         held_byte;
  logic               held_select;
  logic [3:0]         nibble_pins;
  logic               select_pin;
  logic               strobe_pin;

  logic [PHASE_W-1:0] phase_next;
  logic [WAIT_W-1:0]  wait_ticks_next;
  logic [7:0]         held_byte_next;
  logic               held_select_next;
  logic [3:0]         nibble_pins_next;
  logic               select_pin_next;
  logic               strobe_pin_next;
  logic               refused_next;
  logic               busy_next;

  logic               req_accept;
  logic               is_tick;
  logic               is_send;
  logic               idle;
  logic               run;
  logic [PHASE_W-1:0] run_phase;
  logic [WAIT_W-1:0]  wait_base;
  logic [7:0]         byte_src;
  logic               select_src;
  step_t              step;

  // Take a request whenever the result register is empty or drains this cycle.
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign req_accept    = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign is_tick = (s_axis_tuser == CMD_TICK);
  assign is_send = (s_axis_tuser == CMD_INSTR) || (s_axis_tuser == CMD_CHAR);
  assign idle    = (phase == PH_IDLE) && (wait_ticks == '0);

  // A send while idle starts the user transfer at once; otherwise run the
  // current phase when its wait has expired.
  assign run_phase = (is_send && idle) ? PH_USER : phase;

  clni_step_decode u_decode (
    .phase (run_phase),
    .step  (step)
  );

  always_comb begin
    held_byte_next   = held_byte;
    held_select_next = held_select;
    refused_next     = 1'b0;
    wait_base        = wait_ticks;
    run              = 1'b0;

    if (is_tick) begin
      // Count down first, then check whether the next step is due.
      if (wait_ticks != '0) wait_base = wait_ticks - 1'b1;
      run = (wait_base == '0) && (phase != PH_IDLE);
    end else if (is_send) begin
      if (idle) begin
        held_byte_next   = s_axis_tdata;
        held_select_next = (s_axis_tuser == CMD_CHAR);
        run              = 1'b1;
      end else begin
        refused_next = 1'b1;
      end
    end

    // Latch the init byte at its first step; the nibble below uses it directly.
    case (step.load)
      LD_FUNC:  byte_src = function_set;
      LD_DISP:  byte_src = display_control;
      LD_CLEAR: byte_src = CLEAR_CMD;
      LD_ENTRY: byte_src = entry_mode;
      default:  byte_src = held_byte_next;
    endcase
    select_src = (step.load == LD_NONE) ? held_select_next : 1'b0;

    phase_next       = phase;
    wait_ticks_next  = wait_base;
    nibble_pins_next = nibble_pins;
    select_pin_next  = select_pin;
    strobe_pin_next  = strobe_pin;

    if (run) begin
      wait_ticks_next = step.dur;
      phase_next      = (run_phase >= PH_LAST) ? PH_IDLE : run_phase + 1'b1;
      if (step.load != LD_NONE) begin
        held_byte_next   = byte_src;
        held_select_next = 1'b0;
      end
      case (step.nib)
        NIB_CONST: begin
          nibble_pins_next = step.nib_const;
          select_pin_next  = 1'b0;
          strobe_pin_next  = 1'b1;
        end
        NIB_HIGH: begin
          nibble_pins_next = byte_src[7:4];
          select_pin_next  = select_src;
          strobe_pin_next  = 1'b1;
        end
        NIB_LOW: begin
          nibble_pins_next = byte_src[3:0];
          select_pin_next  = select_src;
          strobe_pin_next  = 1'b1;
        end
        default: begin
          if (step.strobe_clr) strobe_pin_next = 1'b0;
        end
      endcase
    end

    busy_next = (phase_next != PH_IDLE) || (wait_ticks_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      function_set    <= RST_FUNCTION_SET;
      display_control <= RST_DISPLAY_CONTROL;
      entry_mode      <= RST_ENTRY_MODE;
    end else if (cfg_valid && cfg_ready) begin
      // Drop writes to indexes beyond the register list.
      case (cfg_index)
        CFG_FUNCTION_SET:    function_set    <= cfg_data;
        CFG_DISPLAY_CONTROL: display_control <= cfg_data;
        CFG_ENTRY_MODE:      entry_mode      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_POWER;
      wait_ticks  <= '0;
      held_byte   <= '0;
      held_select <= 1'b0;
      nibble_pins <= '0;
      select_pin  <= 1'b0;
      strobe_pin  <= 1'b0;
    end else if (req_accept) begin
      phase       <= phase_next;
      wait_ticks  <= wait_ticks_next;
      held_byte   <= held_byte_next;
      held_select <= held_select_next;
      nibble_pins <= nibble_pins_next;
      select_pin  <= select_pin_next;
      strobe_pin  <= strobe_pin_next;
    end
  end

  // Result register: load on accept, hold while the consumer stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (req_accept) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_accept) begin
      m_axis_tdata <= {refused_next, busy_next, strobe_pin_next, select_pin_next,
                       nibble_pins_next};
    end
  end

endmodule

`default_nettype wire

### rtl/clni_checker.sv
// Port-level checker for the character LCD nibble interface, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module clni_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Every accepted request produces a result in the next cycle.
  a_req_to_result: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
    else $error("accepted request gave no result");

  // A refused request means the block was busy and stays so.
  a_refused_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[7] |-> m_axis_tdata[6])
    else $error("refused flagged while not busy");

  // The enable strobe is only high inside a running transfer.
  a_strobe_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[5] |-> m_axis_tdata[6])
    else $error("enable high while idle");

endmodule

bind char_lcd_nibble_interface_unit clni_checker u_clni_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
